/* hw/rtl/rbuc_pkg.sv */
// shared types and constants of the rs485 buffered uart controller
`timescale 1ns / 1ps

package rbuc_pkg;

    localparam int BYTE_W       = 8;
    localparam int DEF_TX_DEPTH = 256;
    localparam int DEF_RX_DEPTH = 256;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 40;

    localparam logic [BYTE_W-1:0] GUARD_RESET = 8'd3;

    typedef enum logic [2:0] {
        MODE_HOST_WRITE = 3'd0,
        MODE_HOST_READ  = 3'd1,
        MODE_LINE_RX    = 3'd2,
        MODE_TX_READY   = 3'd3,
        MODE_TX_DONE    = 3'd4,
        MODE_TICK       = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TX_FULL  = 2'd1,
        ERR_RX_EMPTY = 2'd2,
        ERR_RX_DROP  = 2'd3
    } t_err;

    // per-word status handed from the controller to the output stages
    typedef struct packed {
        logic              line_tx_valid;
        logic              read_valid;
        logic [BYTE_W-1:0] rx_count;
        logic [BYTE_W-1:0] tx_space;
        logic              driver_enable;
        logic              busy;
        t_err              error;
    } t_res;

endpackage

/* hw/rtl/rs485_buffered_uart_control.sv */
// top level of the rs485 half-duplex uart buffer controller
`timescale 1ns / 1ps

// Takes one event word per clock while tready is high (host write, host read, line
// byte, transmitter ready, transmit complete, tick) and returns one status word per
// event, in order. Ring state is updated at the edge that accepts the word; the ring
// byte is read from a ram with a registered read port and joined with the status in
// a second stage, the output register, which presents the status word. Throughput is
// one word per cycle while the receiver keeps up: each event uses at most one port of
// one ring ram. Each ring holds one byte fewer than its depth. The two stages hold two
// words; once both are full and the receiver holds off, tready drops. tready is low
// while reset is held.
module rs485_buffered_uart_control #(
    parameter int TX_DEPTH = rbuc_pkg::DEF_TX_DEPTH,
    parameter int RX_DEPTH = rbuc_pkg::DEF_RX_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [rbuc_pkg::BYTE_W-1:0]        i_cfg_wdata,   // guard_ticks
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // mode[2:0], data_byte[10:3], zero fill
    input  logic [rbuc_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // line_tx_valid[0], line_tx_byte[8:1], read_valid[9], read_byte[17:10],
    // rx_count[25:18], tx_space[33:26], driver_enable[34], busy_res[35],
    // error[37:36], zero fill
    output logic [rbuc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import rbuc_pkg::*;

    localparam int TPW = $clog2(TX_DEPTH);
    localparam int RPW = $clog2(RX_DEPTH);

    logic              accept;
    logic              tx_we, tx_re, rx_we, rx_re;
    logic [TPW-1:0]    tx_waddr, tx_raddr;
    logic [RPW-1:0]    rx_waddr, rx_raddr;
    logic [BYTE_W-1:0] wdata, tx_q, rx_q;
    t_res              res;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    rbuc_ctrl #(
        .TX_DEPTH (TX_DEPTH),
        .RX_DEPTH (RX_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_mode      (i_s_axis_tdata[2:0]),
        .i_data      (i_s_axis_tdata[10:3]),
        .o_tx_we     (tx_we),
        .o_tx_waddr  (tx_waddr),
        .o_tx_re     (tx_re),
        .o_tx_raddr  (tx_raddr),
        .o_rx_we     (rx_we),
        .o_rx_waddr  (rx_waddr),
        .o_rx_re     (rx_re),
        .o_rx_raddr  (rx_raddr),
        .o_wdata     (wdata),
        .o_res       (res)
    );

    rbuc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (TX_DEPTH)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (wdata),
        .i_re    (tx_re),
        .i_raddr (tx_raddr),
        .o_rdata (tx_q)
    );

    rbuc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RX_DEPTH)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (wdata),
        .i_re    (rx_re),
        .i_raddr (rx_raddr),
        .o_rdata (rx_q)
    );

    rbuc_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_res      (res),
        .i_tx_q     (tx_q),
        .i_rx_q     (rx_q),
        .i_m_ready  (i_m_axis_tready),
        .o_in_ready (o_s_axis_tready),
        .o_m_valid  (o_m_axis_tvalid),
        .o_m_data   (o_m_axis_tdata)
    );

    // driver enable and busy always move together
    a_drv_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[34] == o_m_axis_tdata[35]))
        else $error("driver enable and busy differ");

    // a rejected or dropped event moves no byte
    a_err_no_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata[37:36] != ERR_NONE))
            |-> (!o_m_axis_tdata[0] && !o_m_axis_tdata[9]))
        else $error("byte moved on an error event");

    a_tx_rd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[0] && o_m_axis_tdata[9]))
        else $error("transmit and read byte in one word");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

/* hw/rtl/rbuc_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rbuc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/rbuc_ctrl.sv */
// ring pointers, driver enable and service flags, updated once per accepted word
`timescale 1ns / 1ps

module rbuc_ctrl #(
    parameter int TX_DEPTH = rbuc_pkg::DEF_TX_DEPTH,
    parameter int RX_DEPTH = rbuc_pkg::DEF_RX_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rbuc_pkg::BYTE_W-1:0]      i_cfg_wdata,
    input  logic                             i_accept,
    input  logic [2:0]                       i_mode,
    input  logic [rbuc_pkg::BYTE_W-1:0]      i_data,
    output logic                             o_tx_we,
    output logic [$clog2(TX_DEPTH)-1:0]      o_tx_waddr,
    output logic                             o_tx_re,
    output logic [$clog2(TX_DEPTH)-1:0]      o_tx_raddr,
    output logic                             o_rx_we,
    output logic [$clog2(RX_DEPTH)-1:0]      o_rx_waddr,
    output logic                             o_rx_re,
    output logic [$clog2(RX_DEPTH)-1:0]      o_rx_raddr,
    output logic [rbuc_pkg::BYTE_W-1:0]      o_wdata,
    output rbuc_pkg::t_res                   o_res
);
    import rbuc_pkg::*;

    localparam int TPW = $clog2(TX_DEPTH);
    localparam int RPW = $clog2(RX_DEPTH);
    localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);
    localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);

    logic [TPW-1:0]    r_tx_wp, n_tx_wp, r_tx_rp, n_tx_rp;
    logic [RPW-1:0]    r_rx_wp, n_rx_wp, r_rx_rp, n_rx_rp;
    logic              r_busy, n_busy, r_drv, n_drv;
    logic              r_rdy_svc, n_rdy_svc, r_cmp_svc, n_cmp_svc;
    logic [BYTE_W-1:0] r_guard_left, n_guard_left, r_guard_ticks;

    logic [TPW-1:0] tx_wp_inc, tx_rp_inc;
    logic [RPW-1:0] rx_wp_inc, rx_rp_inc;
    logic [TPW:0]   tx_used;
    logic [RPW:0]   rx_used;
    logic           txv, rdv;
    t_err           err;

    assign tx_wp_inc = (r_tx_wp == TX_LAST) ? '0 : r_tx_wp + 1'b1;
    assign tx_rp_inc = (r_tx_rp == TX_LAST) ? '0 : r_tx_rp + 1'b1;
    assign rx_wp_inc = (r_rx_wp == RX_LAST) ? '0 : r_rx_wp + 1'b1;
    assign rx_rp_inc = (r_rx_rp == RX_LAST) ? '0 : r_rx_rp + 1'b1;

    always_comb begin
        n_tx_wp      = r_tx_wp;
        n_tx_rp      = r_tx_rp;
        n_rx_wp      = r_rx_wp;
        n_rx_rp      = r_rx_rp;
        n_busy       = r_busy;
        n_drv        = r_drv;
        n_rdy_svc    = r_rdy_svc;
        n_cmp_svc    = r_cmp_svc;
        n_guard_left = r_guard_left;
        o_tx_we      = 1'b0;
        o_tx_re      = 1'b0;
        o_rx_we      = 1'b0;
        o_rx_re      = 1'b0;
        txv          = 1'b0;
        rdv          = 1'b0;
        err          = ERR_NONE;
        if (i_accept) begin
            unique case (t_mode'(i_mode))
                MODE_HOST_WRITE: begin
                    // one slot is kept free, so next write pointer on read pointer is full
                    if (tx_wp_inc == r_tx_rp) begin
                        err = ERR_TX_FULL;
                    end else begin
                        o_tx_we = 1'b1;
                        n_tx_wp = tx_wp_inc;
                        if (!r_busy) begin
                            n_drv        = 1'b1;
                            n_busy       = 1'b1;
                            n_cmp_svc    = 1'b0;
                            n_guard_left = r_guard_ticks;
                            n_rdy_svc    = (r_guard_ticks == '0);
                        end
                    end
                end
                MODE_HOST_READ: begin
                    if (r_rx_wp == r_rx_rp) begin
                        err = ERR_RX_EMPTY;
                    end else begin
                        rdv     = 1'b1;
                        o_rx_re = 1'b1;
                        n_rx_rp = rx_rp_inc;
                    end
                end
                MODE_LINE_RX: begin
                    if (rx_wp_inc == r_rx_rp) begin
                        err = ERR_RX_DROP;
                    end else begin
                        o_rx_we = 1'b1;
                        n_rx_wp = rx_wp_inc;
                    end
                end
                MODE_TX_READY: begin
                    if (r_rdy_svc) begin
                        if (r_tx_rp != r_tx_wp) begin
                            txv     = 1'b1;
                            o_tx_re = 1'b1;
                            n_tx_rp = tx_rp_inc;
                        end
                        // ring drained: hand over to transmit-complete service
                        if (n_tx_rp == r_tx_wp) begin
                            n_rdy_svc = 1'b0;
                            n_cmp_svc = 1'b1;
                        end
                    end
                end
                MODE_TX_DONE: begin
                    if (r_cmp_svc) begin
                        if (r_tx_rp == r_tx_wp) begin
                            n_drv  = 1'b0;
                            n_busy = 1'b0;
                        end else begin
                            n_rdy_svc = 1'b1;
                            n_cmp_svc = 1'b0;
                        end
                    end
                end
                MODE_TICK: begin
                    if (r_guard_left != '0) begin
                        n_guard_left = r_guard_left - 1'b1;
                        if (r_guard_left == 8'd1) begin
                            n_rdy_svc = 1'b1;
                            n_cmp_svc = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign tx_used = (n_tx_wp >= n_tx_rp)
                   ? {1'b0, n_tx_wp} - {1'b0, n_tx_rp}
                   : {1'b0, n_tx_wp} + (TPW+1)'(TX_DEPTH) - {1'b0, n_tx_rp};
    assign rx_used = (n_rx_wp >= n_rx_rp)
                   ? {1'b0, n_rx_wp} - {1'b0, n_rx_rp}
                   : {1'b0, n_rx_wp} + (RPW+1)'(RX_DEPTH) - {1'b0, n_rx_rp};

    always_comb begin
        o_res.line_tx_valid = txv;
        o_res.read_valid    = rdv;
        o_res.rx_count      = BYTE_W'(rx_used);
        o_res.tx_space      = BYTE_W'((TPW+1)'(TX_DEPTH - 1) - tx_used);
        o_res.driver_enable = n_drv;
        o_res.busy          = n_busy;
        o_res.error         = err;
    end

    assign o_tx_waddr = r_tx_wp;
    assign o_tx_raddr = r_tx_rp;
    assign o_rx_waddr = r_rx_wp;
    assign o_rx_raddr = r_rx_rp;
    assign o_wdata    = i_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_wp       <= '0;
            r_tx_rp       <= '0;
            r_rx_wp       <= '0;
            r_rx_rp       <= '0;
            r_busy        <= 1'b0;
            r_drv         <= 1'b0;
            r_rdy_svc     <= 1'b0;
            r_cmp_svc     <= 1'b0;
            r_guard_left  <= '0;
        end else begin
            r_tx_wp      <= n_tx_wp;
            r_tx_rp      <= n_tx_rp;
            r_rx_wp      <= n_rx_wp;
            r_rx_rp      <= n_rx_rp;
            r_busy       <= n_busy;
            r_drv        <= n_drv;
            r_rdy_svc    <= n_rdy_svc;
            r_cmp_svc    <= n_cmp_svc;
            r_guard_left <= n_guard_left;
        end
    end

    // a register write takes effect at any edge with the write enable high
    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            r_guard_ticks <= i_cfg_wdata;
        end else if (!i_rst_n) begin
            r_guard_ticks <= GUARD_RESET;
        end
    end

endmodule

/* hw/rtl/rbuc_out.sv */
// status stage aligned with the ram read, then the output register
`timescale 1ns / 1ps

module rbuc_out (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  rbuc_pkg::t_res                      i_res,
    input  logic [rbuc_pkg::BYTE_W-1:0]         i_tx_q,
    input  logic [rbuc_pkg::BYTE_W-1:0]         i_rx_q,
    input  logic                                i_m_ready,
    output logic                                o_in_ready,
    output logic                                o_m_valid,
    output logic [rbuc_pkg::OUT_TDATA_W-1:0]    o_m_data
);
    import rbuc_pkg::*;

    logic              r_s1_valid;
    t_res              r_s1_res;
    logic              r_o_valid;
    t_res              r_o_res;
    logic [BYTE_W-1:0] r_o_tx_byte, r_o_rd_byte;
    logic              s1_adv;

    // stage one moves on whenever the output register is free or being drained
    assign s1_adv     = !r_o_valid || i_m_ready;
    assign o_in_ready = i_rst_n && (!r_s1_valid || s1_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_load;
            end
            if (s1_adv) begin
                r_o_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_in_ready) begin
            r_s1_res <= i_res;
        end
        if (s1_adv && r_s1_valid) begin
            r_o_res     <= r_s1_res;
            r_o_tx_byte <= r_s1_res.line_tx_valid ? i_tx_q : '0;
            r_o_rd_byte <= r_s1_res.read_valid ? i_rx_q : '0;
        end
    end

    assign o_m_valid = r_o_valid;
    assign o_m_data  = {OUT_TDATA_W'({r_o_res.error, r_o_res.busy, r_o_res.driver_enable,
                                      r_o_res.tx_space, r_o_res.rx_count, r_o_rd_byte,
                                      r_o_res.read_valid, r_o_tx_byte,
                                      r_o_res.line_tx_valid})};

endmodule

/* tb/tb.sv */
// self-checking testbench for the rs485 buffered uart controller
`timescale 1ns / 1ps

module tb;
    import rbuc_pkg::*;

    typedef struct {
        logic              line_tx_valid;
        logic [BYTE_W-1:0] line_tx_byte;
        logic              read_valid;
        logic [BYTE_W-1:0] read_byte;
        logic [BYTE_W-1:0] rx_count;
        logic [BYTE_W-1:0] tx_space;
        logic              driver_enable;
        logic              busy;
        t_err              error;
    } t_evt_status;

    // mirrors both rings and the half-duplex service state, one status per word
    class t_status_model;
        logic [BYTE_W-1:0] tx_ring [256];
        logic [BYTE_W-1:0] rx_ring [256];
        logic [BYTE_W-1:0] tx_wp, tx_rp, rx_wp, rx_rp;
        logic [BYTE_W-1:0] guard_ticks, guard_left;
        bit                busy, drv_on, rdy_on, done_on;
        t_evt_status       status_due[$];
        int                mismatch_count;
        int                words_seen;

        function void clear();
            tx_wp = '0; tx_rp = '0; rx_wp = '0; rx_rp = '0;
            guard_ticks = GUARD_RESET;
            guard_left = '0;
            busy = 0; drv_on = 0; rdy_on = 0; done_on = 0;
            status_due.delete();
            mismatch_count = 0;
            words_seen = 0;
        endfunction

        function logic [BYTE_W-1:0] rx_used();
            return rx_wp - rx_rp;
        endfunction

        function logic [BYTE_W-1:0] tx_free();
            return 8'd255 - (tx_wp - tx_rp);
        endfunction

        function int pending();
            return status_due.size();
        endfunction

        function void take_event(logic [2:0] mode, logic [BYTE_W-1:0] data);
            t_evt_status s;
            s = '{default: '0, error: ERR_NONE};
            case (mode)
                MODE_HOST_WRITE: begin
                    if (tx_free() == 0) begin
                        s.error = ERR_TX_FULL;
                    end else begin
                        tx_ring[tx_wp] = data;
                        tx_wp++;
                        if (!busy) begin
                            drv_on = 1;
                            busy = 1;
                            done_on = 0;
                            guard_left = guard_ticks;
                            rdy_on = (guard_left == 0);
                        end
                    end
                end
                MODE_HOST_READ: begin
                    if (rx_wp == rx_rp) begin
                        s.error = ERR_RX_EMPTY;
                    end else begin
                        s.read_valid = 1;
                        s.read_byte = rx_ring[rx_rp];
                        rx_rp++;
                    end
                end
                MODE_LINE_RX: begin
                    if (8'(rx_wp + 8'd1) == rx_rp) begin
                        s.error = ERR_RX_DROP;
                    end else begin
                        rx_ring[rx_wp] = data;
                        rx_wp++;
                    end
                end
                MODE_TX_READY: begin
                    if (rdy_on) begin
                        if (tx_rp != tx_wp) begin
                            s.line_tx_valid = 1;
                            s.line_tx_byte = tx_ring[tx_rp];
                            tx_rp++;
                        end
                        if (tx_rp == tx_wp) begin
                            rdy_on = 0;
                            done_on = 1;
                        end
                    end
                end
                MODE_TX_DONE: begin
                    if (!done_on) begin
                    end else if (tx_rp == tx_wp) begin
                        drv_on = 0;
                        busy = 0;
                    end else begin
                        rdy_on = 1;
                        done_on = 0;
                    end
                end
                MODE_TICK: begin
                    if (guard_left != 0) begin
                        guard_left--;
                        if (guard_left == 0) begin
                            rdy_on = 1;
                            done_on = 0;
                        end
                    end
                end
                default: begin
                end
            endcase
            s.rx_count = rx_used();
            s.tx_space = tx_free();
            s.driver_enable = drv_on;
            s.busy = busy;
            status_due.push_back(s);
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at result %0d: %s", words_seen, msg);
            mismatch_count++;
        endtask

        task cmp(string field, logic [BYTE_W-1:0] got, logic [BYTE_W-1:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h expected %h", field, got, want));
        endtask

        task check_status(logic [OUT_TDATA_W-1:0] w);
            t_evt_status e;
            if (status_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", w));
                return;
            end
            e = status_due.pop_front();
            cmp("line_tx_valid", 8'(w[0]), 8'(e.line_tx_valid));
            cmp("line_tx_byte", w[8:1], e.line_tx_byte);
            cmp("read_valid", 8'(w[9]), 8'(e.read_valid));
            cmp("read_byte", w[17:10], e.read_byte);
            cmp("rx_count", w[25:18], e.rx_count);
            cmp("tx_space", w[33:26], e.tx_space);
            cmp("driver_enable", 8'(w[34]), 8'(e.driver_enable));
            cmp("busy_res", 8'(w[35]), 8'(e.busy));
            cmp("error", 8'(w[37:36]), 8'(e.error));
            words_seen++;
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [BYTE_W-1:0]      cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;

    t_status_model model = new();
    bit idle_on = 1'b1;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int sent_words = 0;

    rs485_buffered_uart_control dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else begin
            m_ready = !(idle_on && $urandom_range(99) < 6);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            model.check_status(m_data);
    end

    task automatic send_word(logic [2:0] mode, logic [BYTE_W-1:0] data);
        if (idle_on && $urandom_range(99) < 6) begin
            @(negedge i_clk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 3)) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_valid = 1'b1;
        s_data = IN_TDATA_W'({data, mode});
        do @(posedge i_clk); while (!s_ready);
        model.take_event(mode, data);
        sent_words++;
    endtask

    task automatic write_guard(logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        s_valid = 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge i_clk);
        cfg_we = 1'b0;
        model.guard_ticks = value;
    endtask

    // walk the service states until the driver drops, with stray words mixed in
    task automatic serve_until_idle();
        int steps;
        steps = 0;
        while (model.busy && steps < 2000) begin
            if ($urandom_range(99) < 12)
                send_word(3'($urandom_range(0, 2)), 8'($urandom));
            else if (model.guard_left != 0)
                send_word(MODE_TICK, 8'($urandom));
            else if (model.rdy_on)
                send_word(MODE_TX_READY, 8'($urandom));
            else
                send_word(MODE_TX_DONE, 8'($urandom));
            steps++;
        end
    endtask

    task automatic fill_tx_ring();
        while (model.tx_free() != 0) send_word(MODE_HOST_WRITE, 8'($urandom));
        repeat (3) send_word(MODE_HOST_WRITE, 8'($urandom));
        serve_until_idle();
    endtask

    task automatic fill_rx_ring();
        while (model.rx_used() != 8'd255) send_word(MODE_LINE_RX, 8'($urandom));
        repeat (3) send_word(MODE_LINE_RX, 8'($urandom));
        while (model.rx_used() != 0) send_word(MODE_HOST_READ, 8'($urandom));
        repeat (2) send_word(MODE_HOST_READ, 8'($urandom));
    endtask

    task automatic random_segment();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) begin
            repeat ($urandom_range(1, 8)) send_word(MODE_HOST_WRITE, 8'($urandom));
            serve_until_idle();
        end else if (pick < 75) begin
            repeat ($urandom_range(1, 12))
                send_word($urandom_range(1) ? MODE_LINE_RX : MODE_HOST_READ, 8'($urandom));
        end else begin
            repeat ($urandom_range(1, 10)) send_word(3'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] guards [5];
        int start;
        model.clear();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty ring and idle service cases, then one full frame
        send_word(MODE_HOST_READ, 8'h00);
        send_word(MODE_TX_READY, 8'hFF);
        send_word(MODE_TX_DONE, 8'h00);
        send_word(MODE_TICK, 8'hFF);
        send_word(3'd6, 8'h00);
        send_word(3'd7, 8'hFF);
        send_word(MODE_LINE_RX, 8'hFF);
        send_word(MODE_LINE_RX, 8'h00);
        send_word(MODE_HOST_READ, 8'h00);
        send_word(MODE_HOST_READ, 8'hFF);
        send_word(MODE_HOST_WRITE, 8'hFF);
        send_word(MODE_HOST_WRITE, 8'h00);
        send_word(MODE_TX_READY, 8'h00);
        repeat (3) send_word(MODE_TICK, 8'h00);
        send_word(MODE_TX_DONE, 8'h00);
        send_word(MODE_TX_READY, 8'h00);
        send_word(MODE_HOST_WRITE, 8'h5A);
        send_word(MODE_TX_READY, 8'h00);
        send_word(MODE_TX_READY, 8'h00);
        send_word(MODE_HOST_WRITE, 8'h3C);
        send_word(MODE_TX_DONE, 8'h00);
        send_word(MODE_TX_READY, 8'h00);
        send_word(MODE_TX_DONE, 8'h00);
        send_word(MODE_TX_DONE, 8'h00);
        // zero guard starts ready service on the first write
        write_guard(8'd0);
        send_word(MODE_HOST_WRITE, 8'hA5);
        send_word(MODE_TX_READY, 8'h00);
        send_word(MODE_TX_DONE, 8'h00);

        guards[0] = 8'd255;
        guards[1] = 8'd1;
        guards[2] = 8'($urandom_range(2, 254));
        guards[3] = 8'd0;
        guards[4] = 8'd3;
        for (int p = 0; p < 5; p++) begin
            write_guard(guards[p]);
            idle_on = (p != 1);
            if (p == 2)
                hold_request = 1'b1;
            if (p == 0) begin
                fill_rx_ring();
                // longest guard runs out once
                send_word(MODE_HOST_WRITE, 8'($urandom));
                serve_until_idle();
            end
            if (p == 3)
                fill_tx_ring();
            start = sent_words;
            while (sent_words < start + 40) random_segment();
        end

        @(negedge i_clk);
        s_valid = 1'b0;
        while (model.pending() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (model.pending() != 0)
            model.report_mismatch($sformatf("%0d results never arrived", model.pending()));
        if (model.mismatch_count == 0)
            $display("rs485_buffered_uart_control test passed");
        else
            $display("rs485_buffered_uart_control test failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("rs485_buffered_uart_control test failed");
        $finish;
    end

endmodule
